FILE: sv/stcc_pkg.sv
package stcc_pkg;

    localparam logic signed [23:0] DRIFT_LIMIT     = 24'sd1000000;
    localparam logic signed [23:0] DRIFT_LIMIT_NEG = -24'sd1000000;
    localparam logic [7:0] VERY_LONG_PRESS = 8'd234;
    localparam logic [7:0] SHORT_PRESS_MAX = 8'd32;
    localparam logic [7:0] PRESS_SAT       = 8'd255;
    localparam logic [5:0] SEC_MAX         = 6'd59;
    localparam logic [5:0] MIN_MAX         = 6'd59;
    localparam logic [4:0] HOUR_MAX_24     = 5'd23;
    localparam logic [4:0] HOUR_MAX_12     = 5'd12;
    localparam logic [4:0] HOUR_RESET      = 5'd12;
    localparam logic [4:0] HOUR_FIRST_24   = 5'd0;
    localparam logic [4:0] HOUR_FIRST_12   = 5'd1;
    localparam logic [3:0] DIGIT_SIGN      = 4'd9;

    localparam logic [3:0] PH_HOUR_TENS  = 4'd0;
    localparam logic [3:0] PH_HOUR_UNITS = 4'd1;
    localparam logic [3:0] PH_MIN_TENS   = 4'd2;
    localparam logic [3:0] PH_MIN_UNITS  = 4'd3;
    localparam logic [3:0] PH_MIN_LAST   = 4'd4;
    localparam logic [3:0] PH_RUN_LAST   = 4'd5;
    localparam logic [3:0] PH_CAL_SIGN   = 4'd6;
    localparam logic [3:0] PH_CAL_HUND   = 4'd7;
    localparam logic [3:0] PH_CAL_TENS   = 4'd8;
    localparam logic [3:0] PH_CAL_UNITS  = 4'd9;

    typedef struct packed {
        logic mode;
        logic button_pressed;
    } t_item;

    typedef struct packed {
        logic [3:0]        digit;
        logic              blank;
        logic [1:0]        run_state;
        logic [4:0]        hours_now;
        logic [5:0]        minutes_now;
        logic [5:0]        seconds_now;
        logic signed [7:0] cal_ppm;
        logic              save_time;
        logic              save_cal;
    } t_result;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } t_tens_units;

    // decimal split of a value below 100
    function automatic t_tens_units split_tens(input logic [6:0] v);
        t_tens_units r;
        logic [6:0]  rem;
        r.tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 7'(10 * k)) begin
                r.tens = 4'(k);
            end
        end
        rem     = v - (7'(r.tens) << 3) - (7'(r.tens) << 1);
        r.units = rem[3:0];
        return r;
    endfunction

endpackage

FILE: sv/single_tube_clock_controller_core.sv
// a word accepted goes into the input register; its result goes into the result register when it fires
// throughput: one word per cycle while the output is not stalled; the whole step is one pass of logic between the
// input register and the result register, and stalls hold both registers
// reset: synchronous active-low; clears both stages and sets the clock to 12:00:00,
// run mode, calibration and drift zero, twelve-hour counting
module single_tube_clock_controller_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic              i_button_pressed,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [3:0]        o_digit,
    output logic              o_blank,
    output logic [1:0]        o_run_state,
    output logic [4:0]        o_hours_now,
    output logic [5:0]        o_minutes_now,
    output logic [5:0]        o_seconds_now,
    output logic signed [7:0] o_cal_ppm,
    output logic              o_save_time,
    output logic              o_save_cal
);

    logic              r_twelve_hour_mode;
    logic              in_valid;
    stcc_pkg::t_item   in_item;
    logic              out_load;
    logic              fire;
    stcc_pkg::t_result step_result;
    stcc_pkg::t_result out_result;

    assign fire = in_valid & out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_twelve_hour_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_twelve_hour_mode <= i_cfg_wdata;
        end
    end

    stcc_in_stage u_in_stage (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_mode           (i_mode),
        .i_button_pressed (i_button_pressed),
        .i_fire           (fire),
        .o_in_stall       (o_in_stall),
        .o_valid          (in_valid),
        .o_item           (in_item)
    );

    stcc_engine u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (fire),
        .i_item             (in_item),
        .i_twelve_hour_mode (r_twelve_hour_mode),
        .o_result           (step_result)
    );

    stcc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_result    (step_result),
        .i_out_stall (i_out_stall),
        .o_load      (out_load),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_digit       = out_result.digit;
    assign o_blank       = out_result.blank;
    assign o_run_state   = out_result.run_state;
    assign o_hours_now   = out_result.hours_now;
    assign o_minutes_now = out_result.minutes_now;
    assign o_seconds_now = out_result.seconds_now;
    assign o_cal_ppm     = out_result.cal_ppm;
    assign o_save_time   = out_result.save_time;
    assign o_save_cal    = out_result.save_cal;

endmodule

FILE: sv/stcc_in_stage.sv
module stcc_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_mode,
    input  logic                 i_button_pressed,
    input  logic                 i_fire,
    output logic                 o_in_stall,
    output logic                 o_valid,
    output stcc_pkg::t_item      o_item
);

    logic            r_valid;
    stcc_pkg::t_item r_item;
    logic            accept;

    assign o_in_stall = r_valid & ~i_fire;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.mode           <= i_mode;
            r_item.button_pressed <= i_button_pressed;
        end
    end

endmodule

FILE: sv/stcc_engine.sv
module stcc_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  stcc_pkg::t_item      i_item,
    input  logic                 i_twelve_hour_mode,
    output stcc_pkg::t_result    o_result
);

    typedef enum logic [1:0] {ST_RUN, ST_HOUR, ST_MIN, ST_CAL} t_mode;
    typedef enum logic [1:0] {EV_NONE, EV_SHORT, EV_LONG, EV_VLONG} t_event;

    logic [5:0]        r_seconds, n_seconds;
    logic [5:0]        r_minutes, n_minutes;
    logic [4:0]        r_hours, n_hours;
    logic signed [7:0] r_cal, n_cal;
    logic signed [23:0] r_drift, n_drift;
    logic [7:0]        r_press, n_press;
    t_mode             r_mode, n_mode;
    logic [3:0]        r_phase, n_phase;

    t_event                 ev;
    logic [3:0]             phase_inc;
    logic [4:0]             hour_inc;
    logic                   save_time;
    logic                   save_cal;
    logic                   lit;
    logic [3:0]             digit;
    logic                   neg;
    logic [7:0]             mag;
    logic                   hund;
    logic [6:0]             mag_rem;
    stcc_pkg::t_tens_units  tu_hour;
    stcc_pkg::t_tens_units  tu_min;
    stcc_pkg::t_tens_units  tu_cal;

    always_comb begin
        n_seconds = r_seconds;
        n_minutes = r_minutes;
        n_hours   = r_hours;
        n_cal     = r_cal;
        n_drift   = r_drift;
        n_press   = r_press;
        n_mode    = r_mode;
        n_phase   = r_phase;
        ev        = EV_NONE;
        save_time = 1'b0;
        save_cal  = 1'b0;
        phase_inc = r_phase + 4'd1;
        hour_inc  = r_hours + 5'd1;
        lit       = 1'b0;
        digit     = 4'd0;

        if (i_item.mode) begin
            if (r_mode == ST_RUN) begin
                n_seconds = r_seconds + 6'd1;
                n_drift   = r_drift + 24'(r_cal);
            end
            case (r_mode)
                ST_RUN: begin
                    n_phase = (phase_inc > stcc_pkg::PH_RUN_LAST) ?
                              stcc_pkg::PH_HOUR_TENS : phase_inc;
                end
                ST_HOUR: begin
                    n_phase = (phase_inc > stcc_pkg::PH_MIN_TENS) ?
                              stcc_pkg::PH_HOUR_TENS : phase_inc;
                end
                ST_MIN: begin
                    n_phase = (phase_inc inside
                              {[stcc_pkg::PH_MIN_TENS:stcc_pkg::PH_MIN_LAST]}) ?
                              phase_inc : stcc_pkg::PH_MIN_TENS;
                end
                default: begin
                    n_phase = (phase_inc inside
                              {[stcc_pkg::PH_CAL_SIGN:stcc_pkg::PH_CAL_UNITS]}) ?
                              phase_inc : stcc_pkg::PH_CAL_SIGN;
                end
            endcase
            if (r_mode == ST_RUN && n_seconds inside {[6'd1:6'd58]}) begin
                if (n_drift >= stcc_pkg::DRIFT_LIMIT) begin
                    n_seconds = n_seconds - 6'd1;
                    n_drift   = n_drift - stcc_pkg::DRIFT_LIMIT;
                end else if (n_drift <= stcc_pkg::DRIFT_LIMIT_NEG) begin
                    n_seconds = n_seconds + 6'd1;
                    n_drift   = n_drift + stcc_pkg::DRIFT_LIMIT;
                end
            end
        end else if (i_item.button_pressed) begin
            if (r_press != stcc_pkg::PRESS_SAT) begin
                n_press = r_press + 8'd1;
            end
        end else begin
            if (r_press >= stcc_pkg::VERY_LONG_PRESS) begin
                ev = EV_VLONG;
            end else if (r_press > stcc_pkg::SHORT_PRESS_MAX) begin
                ev = EV_LONG;
            end else if (r_press != 8'd0) begin
                ev = EV_SHORT;
            end
            n_press = 8'd0;
            case (r_mode)
                ST_RUN: begin
                    if (ev == EV_LONG) begin
                        n_mode  = ST_HOUR;
                        n_phase = stcc_pkg::PH_HOUR_TENS;
                    end else if (ev == EV_VLONG) begin
                        n_mode  = ST_CAL;
                        n_phase = stcc_pkg::PH_CAL_SIGN;
                    end
                end
                ST_HOUR: begin
                    if (ev == EV_LONG) begin
                        n_mode  = ST_MIN;
                        n_phase = stcc_pkg::PH_MIN_TENS;
                    end else if (ev == EV_SHORT) begin
                        if (i_twelve_hour_mode) begin
                            n_hours = (hour_inc > stcc_pkg::HOUR_MAX_12) ?
                                      stcc_pkg::HOUR_FIRST_12 : hour_inc;
                        end else begin
                            n_hours = (hour_inc > stcc_pkg::HOUR_MAX_24) ?
                                      stcc_pkg::HOUR_FIRST_24 : hour_inc;
                        end
                    end
                end
                ST_MIN: begin
                    if (ev == EV_LONG) begin
                        n_mode    = ST_RUN;
                        n_seconds = 6'd0;
                        save_time = 1'b1;
                    end else if (ev == EV_SHORT) begin
                        n_minutes = (r_minutes >= stcc_pkg::MIN_MAX) ?
                                    6'd0 : r_minutes + 6'd1;
                    end
                end
                default: begin
                    if (ev == EV_LONG) begin
                        n_mode   = ST_RUN;
                        save_cal = 1'b1;
                    end else if (ev == EV_SHORT) begin
                        n_cal = r_cal + 8'sd1;
                    end
                end
            endcase
        end

        // carry seconds into minutes and minutes into hours
        if (n_mode == ST_RUN) begin
            if (n_seconds > stcc_pkg::SEC_MAX) begin
                n_minutes = n_minutes + 6'd1;
                n_seconds = 6'd0;
                if (n_minutes inside {6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25, 6'd30,
                                      6'd35, 6'd40, 6'd45, 6'd50, 6'd55, 6'd60}) begin
                    save_time = 1'b1;
                end
            end
            if (n_minutes > stcc_pkg::MIN_MAX) begin
                n_hours   = n_hours + 5'd1;
                n_minutes = 6'd0;
            end
            if (i_twelve_hour_mode) begin
                if (n_hours > stcc_pkg::HOUR_MAX_12) begin
                    n_hours = stcc_pkg::HOUR_FIRST_12;
                end
            end else if (n_hours > stcc_pkg::HOUR_MAX_24) begin
                n_hours = stcc_pkg::HOUR_FIRST_24;
            end
        end

        neg     = n_cal[7];
        mag     = neg ? (~n_cal + 8'd1) : n_cal;
        hund    = (mag >= 8'd100);
        mag_rem = hund ? 7'(mag - 8'd100) : mag[6:0];
        tu_hour = stcc_pkg::split_tens({2'b00, n_hours});
        tu_min  = stcc_pkg::split_tens({1'b0, n_minutes});
        tu_cal  = stcc_pkg::split_tens(mag_rem);

        case (n_mode)
            ST_RUN: begin
                if (n_phase == stcc_pkg::PH_HOUR_TENS && tu_hour.tens == 4'd0) begin
                    n_phase = stcc_pkg::PH_HOUR_UNITS;
                end
                case (n_phase)
                    stcc_pkg::PH_HOUR_TENS:  begin lit = 1'b1; digit = tu_hour.tens;  end
                    stcc_pkg::PH_HOUR_UNITS: begin lit = 1'b1; digit = tu_hour.units; end
                    stcc_pkg::PH_MIN_TENS:   begin lit = 1'b1; digit = tu_min.tens;   end
                    stcc_pkg::PH_MIN_UNITS:  begin lit = 1'b1; digit = tu_min.units;  end
                    default:                 lit = 1'b0;
                endcase
            end
            ST_HOUR: begin
                case (n_phase)
                    stcc_pkg::PH_HOUR_TENS:  begin lit = 1'b1; digit = tu_hour.tens;  end
                    stcc_pkg::PH_HOUR_UNITS: begin lit = 1'b1; digit = tu_hour.units; end
                    default:                 lit = 1'b0;
                endcase
            end
            ST_MIN: begin
                case (n_phase)
                    stcc_pkg::PH_MIN_TENS:   begin lit = 1'b1; digit = tu_min.tens;   end
                    stcc_pkg::PH_MIN_UNITS:  begin lit = 1'b1; digit = tu_min.units;  end
                    default:                 lit = 1'b0;
                endcase
            end
            default: begin
                if (n_phase == stcc_pkg::PH_CAL_SIGN && !neg) begin
                    n_phase = stcc_pkg::PH_CAL_HUND;
                end
                if (n_phase == stcc_pkg::PH_CAL_HUND && !hund) begin
                    n_phase = stcc_pkg::PH_CAL_TENS;
                end
                case (n_phase)
                    stcc_pkg::PH_CAL_SIGN:  begin lit = 1'b1; digit = stcc_pkg::DIGIT_SIGN; end
                    stcc_pkg::PH_CAL_HUND:  begin lit = 1'b1; digit = {3'b000, hund}; end
                    stcc_pkg::PH_CAL_TENS:  begin lit = 1'b1; digit = tu_cal.tens;  end
                    stcc_pkg::PH_CAL_UNITS: begin lit = 1'b1; digit = tu_cal.units; end
                    default:                lit = 1'b0;
                endcase
            end
        endcase

        if (n_press == stcc_pkg::PRESS_SAT) begin
            lit = 1'b0;
        end
        if (!lit) begin
            digit = 4'd0;
        end

        o_result.digit       = digit;
        o_result.blank       = ~lit;
        o_result.run_state   = n_mode;
        o_result.hours_now   = n_hours;
        o_result.minutes_now = n_minutes;
        o_result.seconds_now = n_seconds;
        o_result.cal_ppm     = n_cal;
        o_result.save_time   = save_time;
        o_result.save_cal    = save_cal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seconds <= 6'd0;
            r_minutes <= 6'd0;
            r_hours   <= stcc_pkg::HOUR_RESET;
            r_cal     <= 8'sd0;
            r_drift   <= 24'sd0;
            r_press   <= 8'd0;
            r_mode    <= ST_RUN;
            r_phase   <= stcc_pkg::PH_HOUR_TENS;
        end else if (i_fire) begin
            r_seconds <= n_seconds;
            r_minutes <= n_minutes;
            r_hours   <= n_hours;
            r_cal     <= n_cal;
            r_drift   <= n_drift;
            r_press   <= n_press;
            r_mode    <= n_mode;
            r_phase   <= n_phase;
        end
    end

`ifndef SYNTHESIS
    a_cal_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ST_CAL) |-> (r_phase >= stcc_pkg::PH_CAL_SIGN &&
                                r_phase <= stcc_pkg::PH_CAL_UNITS))
        else $error("calibration phase out of range");
    a_hour_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ST_HOUR) |-> (r_phase <= stcc_pkg::PH_MIN_TENS))
        else $error("set hour phase out of range");
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_minutes <= stcc_pkg::MIN_MAX && r_seconds <= stcc_pkg::SEC_MAX &&
         r_hours <= stcc_pkg::HOUR_MAX_24))
        else $error("time field out of range");
    a_save_cal_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.save_cal) |=> (r_mode == ST_RUN))
        else $error("save_cal without return to run");
    a_press_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_item.mode && i_item.button_pressed &&
         r_press != stcc_pkg::PRESS_SAT) |=> (r_press == $past(r_press) + 8'd1))
        else $error("press length not counted");
`endif

endmodule

FILE: sv/stcc_out_stage.sv
module stcc_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  stcc_pkg::t_result    i_result,
    input  logic                 i_out_stall,
    output logic                 o_load,
    output logic                 o_out_valid,
    output stcc_pkg::t_result    o_result
);

    logic              r_valid;
    stcc_pkg::t_result r_result;

    assign o_load      = ~r_valid | ~i_out_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef enum logic [1:0] {
        MS_RUN,
        MS_SET_HOUR,
        MS_SET_MIN,
        MS_SET_CAL
    } t_ctl_mode;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_SHORT,
        EV_LONG,
        EV_VERY_LONG
    } t_press_ev;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_LONG
    } t_stall_style;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_mode = 1'b0;
    logic              i_button_pressed = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_wdata = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [3:0]        o_digit;
    logic              o_blank;
    logic [1:0]        o_run_state;
    logic [4:0]        o_hours_now;
    logic [5:0]        o_minutes_now;
    logic [5:0]        o_seconds_now;
    logic signed [7:0] o_cal_ppm;
    logic              o_save_time;
    logic              o_save_cal;

    // clock model kept alongside the block
    logic              twelve_hr = 1'b1;
    logic [5:0]        tm_sec = 6'd0;
    logic [5:0]        tm_min = 6'd0;
    logic [4:0]        tm_hour = stcc_pkg::HOUR_RESET;
    logic signed [7:0] cal_q = 8'sd0;
    int                drift_acc = 0;
    logic [7:0]        press_cnt = 8'd0;
    t_ctl_mode         ctl_mode = MS_RUN;
    logic [3:0]        disp_phase = stcc_pkg::PH_HOUR_TENS;

    stcc_pkg::t_item   pending_words[$];
    stcc_pkg::t_result expected_words[$];
    stcc_pkg::t_item   next_word;
    stcc_pkg::t_result want;

    int n_queued = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_fail = 0;
    int n_ticks = 0;
    int n_short = 0;
    int n_long = 0;
    int n_very_long = 0;
    int n_drift_fix = 0;
    int n_format_writes = 0;
    int burst_left = 0;
    int gap_left = 0;
    int cycle_cnt = 0;
    t_stall_style stall_style = STALL_NONE;

    single_tube_clock_controller_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_button_pressed (i_button_pressed),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digit          (o_digit),
        .o_blank          (o_blank),
        .o_run_state      (o_run_state),
        .o_hours_now      (o_hours_now),
        .o_minutes_now    (o_minutes_now),
        .o_seconds_now    (o_seconds_now),
        .o_cal_ppm        (o_cal_ppm),
        .o_save_time      (o_save_time),
        .o_save_cal       (o_save_cal)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [4:0] wrap_hour(input logic [4:0] h);
        if (twelve_hr) begin
            return (h > stcc_pkg::HOUR_MAX_12) ? stcc_pkg::HOUR_FIRST_12 : h;
        end
        return (h > stcc_pkg::HOUR_MAX_24) ? stcc_pkg::HOUR_FIRST_24 : h;
    endfunction

    task automatic advance_clock(input stcc_pkg::t_item w);
        stcc_pkg::t_result r;
        t_press_ev         ev;
        int                mag;
        logic              lit;
        logic [3:0]        dig;
        r = '0;
        ev = EV_NONE;
        if (w.mode) begin
            n_ticks++;
            if (ctl_mode == MS_RUN) begin
                tm_sec = tm_sec + 6'd1;
                drift_acc = drift_acc + int'(cal_q);
            end
            disp_phase = disp_phase + 4'd1;
            case (ctl_mode)
                MS_RUN: begin
                    if (disp_phase > stcc_pkg::PH_RUN_LAST)
                        disp_phase = stcc_pkg::PH_HOUR_TENS;
                end
                MS_SET_HOUR: begin
                    if (disp_phase > stcc_pkg::PH_MIN_TENS)
                        disp_phase = stcc_pkg::PH_HOUR_TENS;
                end
                MS_SET_MIN: begin
                    if (disp_phase > stcc_pkg::PH_MIN_LAST ||
                        disp_phase < stcc_pkg::PH_MIN_TENS)
                        disp_phase = stcc_pkg::PH_MIN_TENS;
                end
                default: begin
                    if (disp_phase > stcc_pkg::PH_CAL_UNITS ||
                        disp_phase < stcc_pkg::PH_CAL_SIGN)
                        disp_phase = stcc_pkg::PH_CAL_SIGN;
                end
            endcase
            // drift correction only away from the minute boundary
            if (ctl_mode == MS_RUN && tm_sec > 6'd0 && tm_sec < stcc_pkg::SEC_MAX) begin
                if (drift_acc >= int'(stcc_pkg::DRIFT_LIMIT)) begin
                    tm_sec = tm_sec - 6'd1;
                    drift_acc = drift_acc - int'(stcc_pkg::DRIFT_LIMIT);
                    n_drift_fix++;
                end else if (drift_acc <= int'(stcc_pkg::DRIFT_LIMIT_NEG)) begin
                    tm_sec = tm_sec + 6'd1;
                    drift_acc = drift_acc + int'(stcc_pkg::DRIFT_LIMIT);
                    n_drift_fix++;
                end
            end
        end else if (w.button_pressed) begin
            if (press_cnt != stcc_pkg::PRESS_SAT) press_cnt = press_cnt + 8'd1;
        end else begin
            if (press_cnt >= stcc_pkg::VERY_LONG_PRESS) begin
                ev = EV_VERY_LONG;
                n_very_long++;
            end else if (press_cnt > stcc_pkg::SHORT_PRESS_MAX) begin
                ev = EV_LONG;
                n_long++;
            end else if (press_cnt != 8'd0) begin
                ev = EV_SHORT;
                n_short++;
            end
            press_cnt = 8'd0;
            case (ctl_mode)
                MS_RUN: begin
                    if (ev == EV_LONG) begin
                        ctl_mode = MS_SET_HOUR;
                        disp_phase = stcc_pkg::PH_HOUR_TENS;
                    end else if (ev == EV_VERY_LONG) begin
                        ctl_mode = MS_SET_CAL;
                        disp_phase = stcc_pkg::PH_CAL_SIGN;
                    end
                end
                MS_SET_HOUR: begin
                    if (ev == EV_LONG) begin
                        ctl_mode = MS_SET_MIN;
                        disp_phase = stcc_pkg::PH_MIN_TENS;
                    end else if (ev == EV_SHORT) begin
                        tm_hour = wrap_hour(tm_hour + 5'd1);
                    end
                end
                MS_SET_MIN: begin
                    if (ev == EV_LONG) begin
                        ctl_mode = MS_RUN;
                        tm_sec = 6'd0;
                        r.save_time = 1'b1;
                    end else if (ev == EV_SHORT) begin
                        tm_min = tm_min + 6'd1;
                        if (tm_min > stcc_pkg::MIN_MAX) tm_min = 6'd0;
                    end
                end
                default: begin
                    if (ev == EV_LONG) begin
                        ctl_mode = MS_RUN;
                        r.save_cal = 1'b1;
                    end else if (ev == EV_SHORT) begin
                        cal_q = cal_q + 8'sd1;
                    end
                end
            endcase
        end

        if (ctl_mode == MS_RUN) begin
            if (tm_sec > stcc_pkg::SEC_MAX) begin
                tm_min = tm_min + 6'd1;
                tm_sec = 6'd0;
                if (tm_min % 5 == 0) r.save_time = 1'b1;
            end
            if (tm_min > stcc_pkg::MIN_MAX) begin
                tm_hour = tm_hour + 5'd1;
                tm_min = 6'd0;
            end
            tm_hour = wrap_hour(tm_hour);
        end

        mag = (cal_q < 0) ? -int'(cal_q) : int'(cal_q);
        lit = 1'b1;
        dig = 4'd0;
        case (ctl_mode)
            MS_RUN: begin
                // leading zero of the hour is skipped
                if (disp_phase == stcc_pkg::PH_HOUR_TENS && tm_hour / 10 == 0)
                    disp_phase = stcc_pkg::PH_HOUR_UNITS;
                case (disp_phase)
                    stcc_pkg::PH_HOUR_TENS:  dig = 4'(tm_hour / 10);
                    stcc_pkg::PH_HOUR_UNITS: dig = 4'(tm_hour % 10);
                    stcc_pkg::PH_MIN_TENS:   dig = 4'(tm_min / 10);
                    stcc_pkg::PH_MIN_UNITS:  dig = 4'(tm_min % 10);
                    default:                 lit = 1'b0;
                endcase
            end
            MS_SET_HOUR: begin
                case (disp_phase)
                    stcc_pkg::PH_HOUR_TENS:  dig = 4'(tm_hour / 10);
                    stcc_pkg::PH_HOUR_UNITS: dig = 4'(tm_hour % 10);
                    default:                 lit = 1'b0;
                endcase
            end
            MS_SET_MIN: begin
                case (disp_phase)
                    stcc_pkg::PH_MIN_TENS:  dig = 4'(tm_min / 10);
                    stcc_pkg::PH_MIN_UNITS: dig = 4'(tm_min % 10);
                    default:                lit = 1'b0;
                endcase
            end
            default: begin
                if (disp_phase == stcc_pkg::PH_CAL_SIGN && cal_q >= 0)
                    disp_phase = stcc_pkg::PH_CAL_HUND;
                if (disp_phase == stcc_pkg::PH_CAL_HUND && mag / 100 == 0)
                    disp_phase = stcc_pkg::PH_CAL_TENS;
                case (disp_phase)
                    stcc_pkg::PH_CAL_SIGN:  dig = stcc_pkg::DIGIT_SIGN;
                    stcc_pkg::PH_CAL_HUND:  dig = 4'(mag / 100);
                    stcc_pkg::PH_CAL_TENS:  dig = 4'((mag / 10) % 10);
                    stcc_pkg::PH_CAL_UNITS: dig = 4'(mag % 10);
                    default:                lit = 1'b0;
                endcase
            end
        endcase
        if (press_cnt == stcc_pkg::PRESS_SAT) lit = 1'b0;
        if (!lit) dig = 4'd0;

        r.digit = dig;
        r.blank = !lit;
        r.run_state = ctl_mode;
        r.hours_now = tm_hour;
        r.minutes_now = tm_min;
        r.seconds_now = tm_sec;
        r.cal_ppm = cal_q;
        expected_words.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            n_fail++;
        end
    endtask

    task automatic push_word(input logic mode, input logic btn);
        pending_words.push_back(stcc_pkg::t_item'{mode: mode, button_pressed: btn});
        n_queued++;
    endtask

    // held samples with the odd tick slipped in, then the release
    task automatic push_press(input int len);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0) push_word(1'b1, 1'($urandom_range(0, 1)));
            push_word(1'b0, 1'b1);
        end
        push_word(1'b0, 1'b0);
    endtask

    task automatic push_ticks(input int n);
        for (int k = 0; k < n; k++) push_word(1'b1, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_hour_format(input logic twelve);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= twelve;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        twelve_hr = twelve;
        n_format_writes++;
    endtask

    task automatic random_phase(input int n);
        int target;
        int pick;
        target = n_queued + n;
        while (n_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                push_press($urandom_range(1, 32));
            end else if (pick < 55) begin
                case ($urandom_range(0, 9))
                    0:       push_press(233);
                    1:       push_press(33);
                    2:       push_press($urandom_range(34, 232));
                    default: push_press($urandom_range(33, 48));
                endcase
            end else if (pick < 60) begin
                case ($urandom_range(0, 3))
                    0:       push_press(234);
                    1:       push_press(255);
                    2:       push_press($urandom_range(256, 300));
                    default: push_press($urandom_range(235, 254));
                endcase
            end else if (pick < 85) begin
                push_ticks($urandom_range(1, 70));
            end else begin
                repeat ($urandom_range(1, 8))
                    push_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // walk back to run, open calibration, step it to the target and leave
    task automatic calibrate_to(input logic signed [7:0] target);
        logic [7:0] steps;
        push_word(1'b0, 1'b0);
        wait_idle();
        case (ctl_mode)
            MS_SET_HOUR: begin
                push_press(40);
                push_press(40);
            end
            MS_SET_MIN: push_press(40);
            MS_SET_CAL: push_press(40);
            default: ;
        endcase
        push_press(240);
        steps = 8'(target - cal_q);
        for (int k = 0; k < int'(steps); k++) push_press($urandom_range(1, 2));
        push_press(50);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                n_accepted++;
                advance_clock(stcc_pkg::t_item'{mode: i_mode,
                                                button_pressed: i_button_pressed});
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    next_word = pending_words.pop_front();
                    i_mode <= next_word.mode;
                    i_button_pressed <= next_word.button_pressed;
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 7) == 0) ?
                                     $urandom_range(100, 400) : $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt % 300 == 0) stall_style = t_stall_style'($urandom_range(0, 3));
        case (stall_style)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_RANDOM:   i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: i_out_stall <= (cycle_cnt % 5 < 2);
            default:        i_out_stall <= cycle_cnt[4];
        endcase
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_checked++;
            if (expected_words.size() == 0) begin
                $error("result word with no expectation pending");
                n_fail++;
            end else begin
                want = expected_words.pop_front();
                check_field("digit", 32'(want.digit), 32'(o_digit));
                check_field("blank", 32'(want.blank), 32'(o_blank));
                check_field("run_state", 32'(want.run_state), 32'(o_run_state));
                check_field("hours_now", 32'(want.hours_now), 32'(o_hours_now));
                check_field("minutes_now", 32'(want.minutes_now), 32'(o_minutes_now));
                check_field("seconds_now", 32'(want.seconds_now), 32'(o_seconds_now));
                check_field("cal_ppm", {24'd0, want.cal_ppm}, {24'd0, o_cal_ppm});
                check_field("save_time", 32'(want.save_time), 32'(o_save_time));
                check_field("save_cal", 32'(want.save_cal), 32'(o_save_cal));
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_ticks(3);
        push_press(1);
        push_press(32);
        push_press(33);
        push_press(1);
        push_ticks(3);
        push_press(233);
        push_press(2);
        push_ticks(4);
        push_press(34);
        push_press(234);
        push_press(3);
        push_ticks(5);
        push_press(60);
        push_press(260);
        push_press(40);
        push_ticks(2);
        wait_idle();

        // take the calibration to its negative extreme and let it run
        calibrate_to(-8'sd128);
        push_ticks(20);
        wait_idle();

        set_hour_format(1'b0);
        random_phase(100);
        wait_idle();
        set_hour_format(1'b1);
        random_phase(100);
        wait_idle();

        $display("checked %0d result words: %0d ticks, %0d short, %0d long presses",
                 n_checked, n_ticks, n_short, n_long);
        $display("%0d very long presses, %0d drift corrections, %0d hour-format writes",
                 n_very_long, n_drift_fix, n_format_writes);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: single_tube_clock_controller_core.f
sv/stcc_pkg.sv
sv/stcc_in_stage.sv
sv/stcc_engine.sv
sv/stcc_out_stage.sv
sv/single_tube_clock_controller_core.sv
test/tb.sv
